@@ rtl/rlps_pkg.sv @@
package rlps_pkg;

  // Geometry
  localparam int unsigned DOT_COUNT   = 24;
  localparam int unsigned STORE_LEN   = 3 * DOT_COUNT;
  localparam int unsigned FRAME_BYTES = (STORE_LEN + 7) / 8;
  localparam int unsigned ROWS        = (DOT_COUNT + 7) / 8;
  localparam int unsigned ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned BPOS_W      = $clog2(FRAME_BYTES);

  localparam logic [7:0] DOT_LIMIT = 8'(DOT_COUNT);

  // Field widths
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned DOT_W   = 5;
  localparam int unsigned LEVEL_W = 8;

  // Function codes
  localparam logic [FUNC_W-1:0] FUNC_SHIFT = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_RGB   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_RED   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_GREEN = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_BLUE  = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_WHITE = 3'd5;

  // Bank selection for bit j of a byte
  typedef struct packed {
    logic       used;
    logic [1:0] col;
    logic [2:0] lane;
  } lane_sel_t;

  typedef lane_sel_t [7:0]                  byte_sel_t;
  typedef byte_sel_t [FRAME_BYTES-1:0]      sel_tab_t;
  typedef logic [2:0][7:0][ROW_W-1:0]       row_set_t;
  typedef row_set_t [FRAME_BYTES-1:0]       row_tab_t;

  // Store write request
  typedef struct packed {
    logic [2:0]              col_we;
    logic [DOT_W-1:0]        dot;
    logic [2:0][LEVEL_W-1:0] level;
  } store_wr_t;

  // Store read request
  typedef struct packed {
    logic              re;
    logic [BPOS_W-1:0] byte_pos;
  } store_rd_t;

  function automatic sel_tab_t build_sel_tab();
    sel_tab_t t;
    int       idx;
    int       c;
    int       d;
    t = '0;
    for (int k = 0; k < FRAME_BYTES; k++) begin
      for (int j = 0; j < 8; j++) begin
        idx = k * 8 + j;
        if (idx < STORE_LEN) begin
          c = idx / DOT_COUNT;
          d = idx - c * DOT_COUNT;
          t[k][j].used = 1'b1;
          t[k][j].col  = 2'(c);
          t[k][j].lane = 3'(d % 8);
        end
      end
    end
    return t;
  endfunction

  function automatic row_tab_t build_row_tab();
    row_tab_t t;
    int       idx;
    int       c;
    int       d;
    t = '0;
    for (int k = 0; k < FRAME_BYTES; k++) begin
      for (int j = 0; j < 8; j++) begin
        idx = k * 8 + j;
        if (idx < STORE_LEN) begin
          c = idx / DOT_COUNT;
          d = idx - c * DOT_COUNT;
          t[k][c][d % 8] = ROW_W'(d / 8);
        end
      end
    end
    return t;
  endfunction

  localparam sel_tab_t SEL_TAB = build_sel_tab();
  localparam row_tab_t ROW_TAB = build_row_tab();

endpackage

@@ rtl/rlps_req_if.sv @@
interface rlps_req_if;
  import rlps_pkg::*;

  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [DOT_W-1:0]   dot_index;
  logic [LEVEL_W-1:0] red_level;
  logic [LEVEL_W-1:0] green_level;
  logic [LEVEL_W-1:0] blue_level;

  modport source (
    output valid, func, dot_index, red_level, green_level, blue_level,
    input  ready
  );

  modport sink (
    input  valid, func, dot_index, red_level, green_level, blue_level,
    output ready
  );
endinterface

@@ rtl/rlps_res_if.sv @@
interface rlps_res_if;
  import rlps_pkg::*;

  logic         valid;
  logic         ready;
  logic [7:0]   shift_byte;
  logic         latch_pulse;

  modport source (
    output valid, shift_byte, latch_pulse,
    input  ready
  );

  modport sink (
    input  valid, shift_byte, latch_pulse,
    output ready
  );
endinterface

@@ rtl/rlps_ram.sv @@
module rlps_ram #(
  parameter  int unsigned WIDTH = 8,
  parameter  int unsigned DEPTH = 4,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/rlps_level_store.sv @@
module rlps_level_store (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  rlps_pkg::store_wr_t                wr_i,
  input  rlps_pkg::store_rd_t                rd_i,
  output logic [7:0][rlps_pkg::LEVEL_W-1:0]  level_o
);
  import rlps_pkg::*;

  // One bank per colour and lane; row = dot / 8, lane = dot % 8.
  logic [2:0][7:0]                  ram_we;
  logic [2:0][7:0][ROW_W-1:0]       ram_addr;
  logic [2:0][7:0][LEVEL_W-1:0]     ram_rdata;
  logic [ROW_W-1:0]                 wr_row;

  // Written flags, cleared by reset; unwritten entries read as zero.
  logic [2:0][7:0][(1<<ROW_W)-1:0]  vld_q, vld_d;
  byte_sel_t                        sel_d, sel_q;
  logic [7:0]                       hit_d, hit_q;

  assign wr_row = ROW_W'(wr_i.dot >> 3);

  always_comb begin
    vld_d = vld_q;
    for (int c = 0; c < 3; c++) begin
      for (int l = 0; l < 8; l++) begin
        ram_we[c][l]   = wr_i.col_we[c] && (wr_i.dot[2:0] == 3'(l));
        ram_addr[c][l] = ram_we[c][l] ? wr_row : ROW_TAB[rd_i.byte_pos][c][l];
        if (ram_we[c][l]) begin
          vld_d[c][l][wr_row] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    sel_d = SEL_TAB[rd_i.byte_pos];
    for (int j = 0; j < 8; j++) begin
      hit_d[j] = sel_d[j].used &&
                 vld_q[sel_d[j].col][sel_d[j].lane]
                      [ROW_TAB[rd_i.byte_pos][sel_d[j].col][sel_d[j].lane]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.re) begin
      sel_q <= sel_d;
      hit_q <= hit_d;
    end
  end

  for (genvar c = 0; c < 3; c++) begin : g_col
    for (genvar l = 0; l < 8; l++) begin : g_lane
      rlps_ram #(
        .WIDTH (LEVEL_W),
        .DEPTH (ROWS)
      ) u_ram (
        .clk_i   (clk_i),
        .we_i    (ram_we[c][l]),
        .re_i    (rd_i.re),
        .addr_i  (ram_addr[c][l]),
        .wdata_i (wr_i.level[c]),
        .rdata_o (ram_rdata[c][l])
      );
    end
  end

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      level_o[j] = hit_q[j] ? ram_rdata[sel_q[j].col][sel_q[j].lane] : '0;
    end
  end

endmodule

@@ rtl/rgb_led_pwm_shift_out_top.sv @@
// Throughput: one request per cycle, write or shift, no bubbles while res_o accepts results.
// A shift result reaches res_o through the registered read of the level banks,
//   then the result register; a stalled res_o holds it in the read stage.
// Write requests give no result and are visible to a shift taken in the next cycle.
// Reset (async, active low): levels read as zero, byte position 0,
//   pwm_max and PWM step 255, pipeline empty.
module rgb_led_pwm_shift_out_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  rlps_req_if.sink    req_i,
  rlps_res_if.source  res_o
);
  import rlps_pkg::*;

  // Control state
  logic [7:0]          pwm_max_q;
  logic [7:0]          step_q, step_d;
  logic [BPOS_W-1:0]   bpos_q, bpos_d;

  // Read stage (level banks hold the data, these hold the rest)
  logic                s1_vld_q, s1_vld_d;
  logic [7:0]          s1_step_q;
  logic                s1_latch_q;

  // Result register
  logic                out_vld_q, out_vld_d;
  logic [7:0]          out_byte_q;
  logic                out_latch_q;

  logic                accept;
  logic                is_shift;
  logic                dot_ok;
  logic                last_byte;
  logic                out_load;
  logic                s1_go;
  logic [7:0]          cmp_bits;
  logic [7:0][LEVEL_W-1:0] level;

  store_wr_t           wr;
  store_rd_t           rd;

  // Read stage moves on whenever the result register is free or being drained.
  assign out_load    = !out_vld_q || res_o.ready;
  assign s1_go       = s1_vld_q && out_load;
  assign req_i.ready = !s1_vld_q || out_load;

  assign accept    = req_i.valid && req_i.ready;
  assign is_shift  = (req_i.func == FUNC_SHIFT);
  assign dot_ok    = ({3'b000, req_i.dot_index} < DOT_LIMIT);
  assign last_byte = (bpos_q == BPOS_W'(FRAME_BYTES - 1));

  assign rd.re       = accept && is_shift;
  assign rd.byte_pos = bpos_q;

  // Write decode: white copies the red level to all three colours.
  always_comb begin
    wr.dot    = req_i.dot_index;
    wr.col_we = 3'b000;
    wr.level  = {req_i.blue_level, req_i.green_level, req_i.red_level};
    case (req_i.func)
      FUNC_RGB:   wr.col_we = 3'b111;
      FUNC_RED:   wr.col_we = 3'b001;
      FUNC_GREEN: wr.col_we = 3'b010;
      FUNC_BLUE:  wr.col_we = 3'b100;
      FUNC_WHITE: begin
        wr.col_we = 3'b111;
        wr.level  = {req_i.red_level, req_i.red_level, req_i.red_level};
      end
      default:    wr.col_we = 3'b000;
    endcase
    if (!(accept && dot_ok)) begin
      wr.col_we = 3'b000;
    end
  end

  rlps_level_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (wr),
    .rd_i    (rd),
    .level_o (level)
  );

  // Frame position and PWM step advance once per shift; step counts down
  // and reloads from pwm_max after zero.
  always_comb begin
    bpos_d = bpos_q;
    step_d = step_q;
    if (rd.re) begin
      bpos_d = last_byte ? '0 : bpos_q + 1'b1;
      step_d = (step_q == 8'd0) ? pwm_max_q : step_q - 8'd1;
    end
  end

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (rd.re) begin
      s1_vld_d = 1'b1;
    end else if (s1_go) begin
      s1_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (s1_go) begin
      out_vld_d = 1'b1;
    end else if (res_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  // Bit j is on while the step is below its level.
  always_comb begin
    for (int j = 0; j < 8; j++) begin
      cmp_bits[j] = (s1_step_q < level[j]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pwm_max_q <= 8'd255;
      step_q    <= 8'd255;
      bpos_q    <= '0;
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        pwm_max_q <= cfg_wdata_i;
      end
      step_q    <= step_d;
      bpos_q    <= bpos_d;
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd.re) begin
      s1_step_q  <= step_q;
      s1_latch_q <= last_byte;
    end
    if (s1_go) begin
      out_byte_q  <= cmp_bits;
      out_latch_q <= s1_latch_q;
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.shift_byte  = out_byte_q;
  assign res_o.latch_pulse = out_latch_q;

  // Checks
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, bpos_q} < (BPOS_W + 1)'(FRAME_BYTES))
    else $error("byte position beyond frame");

  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd.re && last_byte |=> bpos_q == '0)
    else $error("frame did not wrap after last byte");

  a_reload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd.re && step_q == 8'd0 |=> step_q == $past(pwm_max_q))
    else $error("step did not reload from pwm_max");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && !out_load |-> !req_i.ready)
    else $error("request taken while read stage is stalled");

  a_shift_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go |=> out_vld_q && out_latch_q == $past(s1_latch_q))
    else $error("read stage result lost");

endmodule
